// ===== src/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern scanner.
// Holds the configuration, stage and result structures and the register codes.
// No dependencies.
`timescale 1ns / 1ps

package mbps_pkg;

    // Fixed field widths of the scanner's ports and registers.
    localparam int LEN_W         = 6;
    localparam int OFFSET_W      = 32;
    localparam int COUNT_W       = 16;
    localparam int WORD_W        = 64;
    localparam int PATTERN_WORDS = 4;
    localparam int PATTERN_BYTES = 32;
    localparam int CARE_W        = 32;
    localparam int CFG_INDEX_W   = 3;

    // Result queue sizing.
    localparam int RQ_DEPTH   = 4;
    localparam int RQ_PTR_W   = 2;
    localparam int RQ_COUNT_W = 3;

    // Result kinds.
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_0      = 3'd0,
        REG_PATTERN_1      = 3'd1,
        REG_PATTERN_2      = 3'd2,
        REG_PATTERN_3      = 3'd3,
        REG_CARE_MASK      = 3'd4,
        REG_PATTERN_LENGTH = 3'd5
    } cfg_reg_t;

    // Current configuration as seen by the matcher.
    typedef struct packed {
        logic [PATTERN_BYTES*8-1:0] pattern;
        logic [CARE_W-1:0]          care;
        logic [LEN_W-1:0]           length;
    } cfg_t;

    // Control side of the window stage.
    typedef struct packed {
        logic                valid;
        logic                eos;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    fill;
    } s1_t;

    // One result beat.
    typedef struct packed {
        logic                kind;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  count;
        logic                unique_match;
        logic                last_of_run;
    } res_t;

endpackage

// ===== src/mbps_window.sv =====
// Input stage of the scanner: the byte window shift register and stream position.
// Depends on mbps_pkg.
`timescale 1ns / 1ps

module mbps_window
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        advance,
    input  logic [7:0]                  data_byte,
    input  logic                        end_of_stream,
    output s1_t                         s1,
    output logic [MAX_PATTERN-1:0][7:0] window
);

    logic                        valid_reg;
    logic                        eos_reg;
    logic [OFFSET_W-1:0]         seen_reg;
    logic [OFFSET_W-1:0]         offset_reg;
    logic [LEN_W-1:0]            fill_reg;
    logic [MAX_PATTERN-1:0][7:0] window_reg;

    logic [MAX_PATTERN-1:0][7:0] window_next;
    logic [LEN_W-1:0]            base_fill;
    logic [LEN_W-1:0]            fill_next;
    logic [OFFSET_W-1:0]         offset_next;

    // A byte that follows the end of a stream starts again from offset zero
    // with an empty window.
    always_comb
    begin
        window_next[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
        base_fill   = eos_reg ? '0 : fill_reg;
        fill_next   = (base_fill < LEN_W'(MAX_PATTERN)) ? base_fill + 1'b1 : base_fill;
        offset_next = eos_reg ? '0 : seen_reg;
    end

    // Stage valid and stream position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            eos_reg    <= 1'b0;
            seen_reg   <= '0;
            offset_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            valid_reg <= load | (valid_reg & ~advance);
            if (load)
            begin
                eos_reg    <= end_of_stream;
                seen_reg   <= offset_next + 1'b1;
                offset_reg <= offset_next;
                fill_reg   <= fill_next;
            end
        end
    end

    // Window bytes; the fill count says which of them are valid.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            window_reg <= window_next;
        end
    end

    assign s1.valid  = valid_reg;
    assign s1.eos    = eos_reg;
    assign s1.offset = offset_reg;
    assign s1.fill   = fill_reg;
    assign window    = window_reg;

endmodule

// ===== src/mbps_match.sv =====
// Compare stage: masked window compare, match statistics and result beats.
// Depends on mbps_pkg.
`timescale 1ns / 1ps

module mbps_match
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cfg_t                        cfg,
    input  s1_t                         s1,
    input  logic [MAX_PATTERN-1:0][7:0] window,
    input  logic                        advance,
    output logic [1:0]                  push_n,
    output res_t                        push_a,
    output res_t                        push_b
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Pattern aligned to window positions, refreshed every cycle.
    logic [MAX_PATTERN-1:0][7:0] eff_pat_reg;
    logic [MAX_PATTERN-1:0][7:0] eff_pat_next;
    logic [MAX_PATTERN-1:0]      eff_care_reg;
    logic [MAX_PATTERN-1:0]      eff_care_next;
    logic [LEN_W-1:0]            len_reg;
    logic [LEN_W-1:0]            len_clamp;

    // Stream statistics.
    logic [COUNT_BITS-1:0] matches_reg;
    logic [OFFSET_W-1:0]   first_reg;
    logic                  multi_reg;
    logic [COUNT_BITS-1:0] matches_new;
    logic [OFFSET_W-1:0]   first_new;
    logic                  multi_new;

    logic [MAX_PATTERN-1:0] byte_ok;
    logic                   hit;
    logic [OFFSET_W-1:0]    start;
    res_t                   report;
    res_t                   summary;

    // Window entry k meets pattern byte len-1-k; entries beyond the length never care.
    always_comb
    begin : align_b
        logic [LEN_W-1:0] idx;
        len_clamp = (cfg.length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : cfg.length;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            idx              = LEN_W'(len_clamp - LEN_W'(k) - LEN_W'(1));
            eff_care_next[k] = (LEN_W'(k) < len_clamp) & cfg.care[idx[4:0]];
            eff_pat_next[k]  = cfg.pattern[{idx[4:0], 3'b000} +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_care_reg <= '0;
            len_reg      <= '0;
        end
        else
        begin
            eff_care_reg <= eff_care_next;
            len_reg      <= len_clamp;
        end
    end

    always_ff @(posedge clk)
    begin
        eff_pat_reg <= eff_pat_next;
    end

    // Masked compare over the whole window.
    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            byte_ok[k] = ~eff_care_reg[k] | (window[k] == eff_pat_reg[k]);
        end
        hit   = (len_reg != '0) && (s1.fill >= len_reg) && (&byte_ok);
        start = s1.offset - OFFSET_W'(len_reg) + 1'b1;
    end

    // Statistics after this byte, before any end-of-stream clear.
    always_comb
    begin
        matches_new = matches_reg;
        first_new   = first_reg;
        multi_new   = multi_reg;
        if (hit)
        begin
            if ((matches_reg == '0) && !multi_reg)
            begin
                first_new = start;
            end
            else
            begin
                multi_new = 1'b1;
            end
            if (matches_reg != COUNT_MAX)
            begin
                matches_new = matches_reg + 1'b1;
            end
        end
    end

    // Result beats: the match report comes before the summary.
    always_comb
    begin
        report.kind         = KIND_MATCH;
        report.offset       = start;
        report.count        = COUNT_W'(matches_new);
        report.unique_match = 1'b0;
        report.last_of_run  = ~s1.eos;

        summary.kind         = KIND_SUMMARY;
        summary.offset       = first_new;
        summary.count        = COUNT_W'(matches_new);
        summary.unique_match = (matches_new != '0) & ~multi_new;
        summary.last_of_run  = 1'b1;

        push_a = hit ? report : summary;
        push_b = summary;
        push_n = advance ? ({1'b0, hit} + {1'b0, s1.eos}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matches_reg <= '0;
            first_reg   <= '0;
            multi_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (s1.eos)
            begin
                matches_reg <= '0;
                first_reg   <= '0;
                multi_reg   <= 1'b0;
            end
            else
            begin
                matches_reg <= matches_new;
                first_reg   <= first_new;
                multi_reg   <= multi_new;
            end
        end
    end

`ifndef SYNTHESIS
    // The end of a stream leaves no matches behind for the next one.
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1.eos |=> (matches_reg == '0) && !multi_reg)
        else $error("match statistics not cleared after end of stream");

    // A repeated match can only be recorded after a first one was counted.
    a_multi_count: assert property (@(posedge clk) disable iff (!rst_n)
        multi_reg |-> (matches_reg != '0))
        else $error("repeat match flag set with zero matches");
`endif

endmodule

// ===== src/mbps_res_queue.sv =====
// Four-entry result queue between the compare stage and the output channel.
// Takes up to two result beats per cycle and hands out one. Depends on mbps_pkg.
`timescale 1ns / 1ps

module mbps_res_queue
    import mbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  res_t       push_a,
    input  res_t       push_b,
    input  logic       out_stall,
    output logic       out_valid,
    output res_t       out_res,
    output logic       room
);

    localparam int SUM_W = RQ_COUNT_W + 1;

    res_t                  entries [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg;
    logic [RQ_COUNT_W-1:0] count_reg;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid & ~out_stall;
    assign out_res   = entries[rd_ptr_reg];

    // Room for the largest burst one byte can cause, without counting this cycle's pop.
    assign room = (count_reg <= RQ_COUNT_W'(RQ_DEPTH - 2));

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + RQ_PTR_W'(pop);
            count_reg  <= count_reg + RQ_COUNT_W'(push_n) - RQ_COUNT_W'(pop);
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            entries[wr_ptr_reg] <= push_a;
        end
        if (push_n == 2'd2)
        begin
            entries[RQ_PTR_W'(wr_ptr_reg + 1'b1)] <= push_b;
        end
    end

`ifndef SYNTHESIS
    // Pushes never overrun the queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(count_reg) + SUM_W'(push_n)) <= (SUM_W'(RQ_DEPTH) + SUM_W'(pop)))
        else $error("result queue overflow");
`endif

endmodule

// ===== src/masked_byte_pattern_scanner.sv =====
// A byte accepted into the window register is compared there and pushed into the result
// queue, whose head drives the output; the push waits while the queue lacks room.
// Throughput: one byte per cycle; an end-of-stream byte that also matches yields two
// beats, and the four-entry result queue stalls the input only when it backs up.
// Reset: rst_n clears configuration, stream counters and the queue at once; no clearing
// pass. Window bytes are not reset and stay hidden behind the zero fill count.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_stream,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   item_kind,
    output logic [OFFSET_W-1:0]    offset,
    output logic [COUNT_W-1:0]     match_count,
    output logic                   unique_match,
    output logic                   last_of_run,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data
);

    logic [PATTERN_WORDS-1:0][WORD_W-1:0] pattern_word_reg;
    logic [CARE_W-1:0]                    care_mask_reg;
    logic [LEN_W-1:0]                     pattern_length_reg;

    cfg_t                        cfg;
    s1_t                         s1;
    logic [MAX_PATTERN-1:0][7:0] window;
    logic                        load;
    logic                        advance;
    logic                        room;
    logic [1:0]                  push_n;
    res_t                        push_a;
    res_t                        push_b;
    res_t                        out_res;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_word_reg   <= '0;
            care_mask_reg      <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index)) inside
                REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3:
                    pattern_word_reg[cfg_index[1:0]] <= cfg_data;
                REG_CARE_MASK:
                    care_mask_reg <= cfg_data[CARE_W-1:0];
                REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg.pattern = pattern_word_reg;
    assign cfg.care    = care_mask_reg;
    assign cfg.length  = pattern_length_reg;

    // Input beat handshake: the window stage moves on when the queue has room.
    assign advance  = s1.valid & room;
    assign in_stall = s1.valid & ~room;
    assign load     = in_valid & ~in_stall;

    mbps_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .advance       (advance),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .s1            (s1),
        .window        (window)
    );

    mbps_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .COUNT_BITS  (COUNT_BITS)
    ) u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .s1      (s1),
        .window  (window),
        .advance (advance),
        .push_n  (push_n),
        .push_a  (push_a),
        .push_b  (push_b)
    );

    mbps_res_queue u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_a    (push_a),
        .push_b    (push_b),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res),
        .room      (room)
    );

    // Output beat fields.
    assign item_kind    = out_res.kind;
    assign offset       = out_res.offset;
    assign match_count  = out_res.count;
    assign unique_match = out_res.unique_match;
    assign last_of_run  = out_res.last_of_run;

`ifndef SYNTHESIS
    // A byte held in the window stage keeps its position until the compare takes it.
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1.valid && !advance |=> s1.valid && $stable(s1.offset) && $stable(s1.eos))
        else $error("window stage lost a byte before it was compared");
`endif

endmodule
